// ----- rtl/sha1_pkg.sv -----
package sha1_pkg;

   // field and store sizes
   localparam int WordWidth   = 32;
   localparam int CountWidth  = 3;
   localparam int DigestWords = 5;
   localparam int IndexWidth  = $clog2(DigestWords);
   localparam int BufDepth    = 16;
   localparam int BufIdxWidth = $clog2(BufDepth);
   localparam int Rounds      = 80;
   localparam int RoundWidth  = $clog2(Rounds);
   localparam int TotalWidth  = 61;

   typedef logic [WordWidth-1:0] word_type;

   localparam logic [CountWidth-1:0] BytesPerWord = 3'd4;

   // initial chaining value
   localparam word_type InitVector [DigestWords] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   // round constants, one per group of twenty rounds
   localparam word_type RoundK0 = 32'h5A827999;
   localparam word_type RoundK1 = 32'h6ED9EBA1;
   localparam word_type RoundK2 = 32'h8F1BBCDC;
   localparam word_type RoundK3 = 32'hCA62C1D6;

   // padding: marker byte, word slot where the length starts, last slot
   localparam logic [7:0]             PadByte     = 8'h80;
   localparam logic [BufIdxWidth-1:0] BufAtLen    = 4'd14;
   localparam logic [BufIdxWidth-1:0] BufLastSlot = 4'd15;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROUND,
      ST_UPDATE,
      ST_PAD,
      ST_ZERO,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_DIGEST
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic absorb;
      logic pad;
      logic shift_zero;
      logic shift_len_hi;
      logic shift_len_lo;
      logic round_start;
      logic round_step;
      logic chain_update;
      logic out_next;
      logic reinit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic absorb_fills;
      logic buf_last_slot;
      logic buf_at_len;
      logic round_last;
      logic out_last;
   } dp_status_type;

endpackage

// ----- rtl/sha1_req_if.sv -----
interface sha1_req_if;
   import sha1_pkg::*;

   logic                  valid;
   logic                  ready;
   word_type              msg_word;
   logic [CountWidth-1:0] valid_bytes;
   logic                  final_word;

   modport source (output valid, msg_word, valid_bytes, final_word, input ready);
   modport sink   (input valid, msg_word, valid_bytes, final_word, output ready);

endinterface

// ----- rtl/sha1_rsp_if.sv -----
interface sha1_rsp_if;
   import sha1_pkg::*;

   logic                  valid;
   logic                  ready;
   word_type              digest_word;
   logic [IndexWidth-1:0] word_index;
   logic                  last_digest_word;

   modport source (output valid, digest_word, word_index, last_digest_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_digest_word, output ready);

endinterface

// ----- rtl/sha1_dp.sv -----
module sha1_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  sha1_pkg::word_type              msg_word,
   input  logic [sha1_pkg::CountWidth-1:0] valid_bytes,
   input  sha1_pkg::ctrl_cmd_type          cmd,
   output sha1_pkg::dp_status_type         status,
   output sha1_pkg::word_type              digest_word,
   output logic [sha1_pkg::IndexWidth-1:0] word_index,
   output logic                            last_digest_word
);
   import sha1_pkg::*;

   word_type               chain_ff [DigestWords];
   word_type               chain_in [DigestWords];
   word_type               w_ff [BufDepth];
   word_type               w_in [BufDepth];
   word_type               a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type               a_in, b_in, c_in, d_in, e_in;
   logic [BufIdxWidth-1:0] wcnt_ff, wcnt_in;
   logic [RoundWidth-1:0]  rcnt_ff, rcnt_in;
   logic [TotalWidth-1:0]  total_ff, total_in;
   logic [23:0]            pend_ff, pend_in;
   logic [1:0]             pcnt_ff, pcnt_in;
   logic [IndexWidth-1:0]  oidx_ff, oidx_in;

   logic [CountWidth-1:0]  cnt;
   logic [CountWidth-1:0]  tot;
   logic                   absorb_shift;
   logic [23:0]            pend_m;
   word_type               word_m;
   logic [55:0]            comb;
   word_type               pad_word;
   logic [63:0]            bits;
   logic                   shift_en;
   word_type               shift_word;
   word_type               f, k, t, sched;

   // byte packing: pending bytes followed by the new word's valid bytes
   always_comb begin
      cnt          = (valid_bytes > BytesPerWord) ? BytesPerWord : valid_bytes;
      pend_m       = pend_ff & ~(24'hFFFFFF >> {pcnt_ff, 3'b000});
      word_m       = msg_word & ~(32'hFFFFFFFF >> {cnt, 3'b000});
      comb         = {pend_m, 32'h0} | ({word_m, 24'h0} >> {pcnt_ff, 3'b000});
      tot          = {1'b0, pcnt_ff} + cnt;
      absorb_shift = tot[2];
      pad_word     = {pend_m, 8'h00} | ({PadByte, 24'h0} >> {pcnt_ff, 3'b000});
      bits         = {total_ff, 3'b000};
   end

   // word entering the block buffer
   always_comb begin
      shift_en   = 1'b1;
      shift_word = '0;
      if (cmd.absorb && absorb_shift) begin
         shift_word = comb[55:24];
      end else if (cmd.pad) begin
         shift_word = pad_word;
      end else if (cmd.shift_zero) begin
         shift_word = '0;
      end else if (cmd.shift_len_hi) begin
         shift_word = bits[63:32];
      end else if (cmd.shift_len_lo) begin
         shift_word = bits[31:0];
      end else begin
         shift_en = 1'b0;
      end
   end

   // one round of the compression function
   always_comb begin
      if (rcnt_ff inside {[7'd0:7'd19]}) begin
         f = d_ff ^ (b_ff & (c_ff ^ d_ff));
         k = RoundK0;
      end else if (rcnt_ff inside {[7'd20:7'd39]}) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = RoundK1;
      end else if (rcnt_ff inside {[7'd40:7'd59]}) begin
         f = (b_ff & c_ff) | (d_ff & (b_ff | c_ff));
         k = RoundK2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = RoundK3;
      end
      t     = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + w_ff[0];
      sched = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      sched = {sched[30:0], sched[31]};
   end

   // next values
   always_comb begin
      w_in     = w_ff;
      wcnt_in  = wcnt_ff;
      pend_in  = pend_ff;
      pcnt_in  = pcnt_ff;
      total_in = total_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      rcnt_in  = rcnt_ff;
      chain_in = chain_ff;
      oidx_in  = oidx_ff;

      // buffer shifts towards slot 0; schedule words refill the top
      if (shift_en || cmd.round_step) begin
         for (int i = 0; i < BufDepth - 1; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[BufDepth-1] = shift_en ? shift_word : sched;
      end
      if (shift_en) begin
         wcnt_in = wcnt_ff + 1'b1;
      end

      if (cmd.absorb) begin
         total_in = total_ff + TotalWidth'(cnt);
         if (absorb_shift) begin
            pend_in = comb[23:0];
            pcnt_in = 2'(tot - BytesPerWord);
         end else begin
            pend_in = comb[55:32];
            pcnt_in = tot[1:0];
         end
      end
      if (cmd.pad) begin
         pcnt_in = '0;
      end

      if (cmd.round_start) begin
         a_in    = chain_in[0];
         b_in    = chain_in[1];
         c_in    = chain_in[2];
         d_in    = chain_in[3];
         e_in    = chain_in[4];
         rcnt_in = '0;
      end else if (cmd.round_step) begin
         a_in    = t;
         b_in    = a_ff;
         c_in    = {b_ff[1:0], b_ff[31:2]};
         d_in    = c_ff;
         e_in    = d_ff;
         rcnt_in = rcnt_ff + 1'b1;
      end

      if (cmd.chain_update) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end

      if (cmd.out_next) begin
         oidx_in = oidx_ff + 1'b1;
      end

      // back to the initial vector once the digest has gone out
      if (cmd.reinit) begin
         chain_in = InitVector;
         wcnt_in  = '0;
         pcnt_in  = '0;
         total_in = '0;
         oidx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= InitVector;
         wcnt_ff  <= '0;
         pcnt_ff  <= '0;
         total_ff <= '0;
         oidx_ff  <= '0;
      end else begin
         chain_ff <= chain_in;
         wcnt_ff  <= wcnt_in;
         pcnt_ff  <= pcnt_in;
         total_ff <= total_in;
         oidx_ff  <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      pend_ff <= pend_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      e_ff    <= e_in;
      rcnt_ff <= rcnt_in;
   end

   // status and digest output
   always_comb begin
      status.absorb_fills  = (wcnt_ff == BufLastSlot) && absorb_shift;
      status.buf_last_slot = (wcnt_ff == BufLastSlot);
      status.buf_at_len    = (wcnt_ff == BufAtLen);
      status.round_last    = (rcnt_ff == RoundWidth'(Rounds - 1));
      status.out_last      = (oidx_ff == IndexWidth'(DigestWords - 1));
      digest_word          = chain_ff[oidx_ff];
      word_index           = oidx_ff;
      last_digest_word     = status.out_last;
   end

endmodule

// ----- rtl/sha1_ctrl.sv -----
module sha1_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_final,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sha1_pkg::ctrl_cmd_type  cmd,
   input  sha1_pkg::dp_status_type status
);
   import sha1_pkg::*;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.absorb = 1'b1;
               if (status.absorb_fills) begin
                  cmd.round_start = 1'b1;
                  state_in        = ST_ROUND;
                  ret_in          = req_final ? ST_PAD : ST_IDLE;
               end else if (req_final) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (status.round_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.chain_update = 1'b1;
            state_in         = ret_ff;
         end
         ST_PAD: begin
            cmd.pad = 1'b1;
            if (status.buf_last_slot) begin
               cmd.round_start = 1'b1;
               state_in        = ST_ROUND;
               ret_in          = ST_ZERO;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (status.buf_at_len) begin
               state_in = ST_LEN_HI;
            end else begin
               cmd.shift_zero = 1'b1;
               if (status.buf_last_slot) begin
                  cmd.round_start = 1'b1;
                  state_in        = ST_ROUND;
                  ret_in          = ST_ZERO;
               end
            end
         end
         ST_LEN_HI: begin
            cmd.shift_len_hi = 1'b1;
            state_in         = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            // length low word always lands in the last slot
            cmd.shift_len_lo = 1'b1;
            cmd.round_start  = 1'b1;
            state_in         = ST_ROUND;
            ret_in           = ST_DIGEST;
         end
         ST_DIGEST: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.out_next = 1'b1;
               if (status.out_last) begin
                  cmd.reinit = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/sha1_hash_engine.sv -----
// Channel  Dir  Payload                                      Transfer
// req      in   msg_word, valid_bytes, final_word            valid & ready
// rsp      out  digest_word, word_index, last_digest_word    valid & ready
//
// A message word is taken whenever the engine is idle. Each full 64-byte
// block then costs 80 rounds plus one chaining add. A final word adds a pad
// word, zero words up to the length slot, two length words, one or two
// compressions and five digest transfers. Reset is synchronous and restores
// the initial vector. req is held off while a block compresses, padding runs
// or the digest is out, stalled by rsp.ready.
module sha1_hash_engine (
   input  logic       clock,
   input  logic       reset,
   sha1_req_if.sink   req,
   sha1_rsp_if.source rsp
);
   import sha1_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   sha1_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_final (req.final_word),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   sha1_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .msg_word         (req.msg_word),
      .valid_bytes      (req.valid_bytes),
      .cmd              (cmd),
      .status           (status),
      .digest_word      (rsp.digest_word),
      .word_index       (rsp.word_index),
      .last_digest_word (rsp.last_digest_word)
   );

endmodule
